>>> hdl/psrfp_pkg.sv
`default_nettype none

package psrfp_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned HELD_N    = FRAME_LEN - 1;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SUM_FIRST = 2;
  localparam int unsigned SUM_LAST  = 7;
  localparam int unsigned CSUM_POS  = 8;

  // Frame markers
  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] CMD_MEAS  = 8'hC0;
  localparam logic [7:0] CMD_ACK   = 8'hC5;
  localparam logic [7:0] TAIL_BYTE = 8'hAB;

  // Frame status codes
  localparam logic [2:0] ST_MEAS    = 3'd0;
  localparam logic [2:0] ST_ACK     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_TAIL    = 3'd4;

  // Bytes 0..8 of the frame in progress
  typedef logic [HELD_N-1:0][7:0] held_bytes_t;

  // One decoded frame
  typedef struct packed {
    logic [2:0]  frame_status;
    logic [15:0] pm25_value;
    logic [15:0] pm10_value;
  } frame_res_t;

endpackage

`default_nettype wire

>>> hdl/psrfp_decode.sv
`default_nettype none

module psrfp_decode import psrfp_pkg::*; (
  input  wire held_bytes_t held,
  input  wire logic [7:0]  sum,
  input  wire logic [7:0]  tail,
  output frame_res_t       res
);

  logic is_head;

  assign is_head = (held[0] == HEAD_BYTE);

  // Status priority: checksum, tail, measurement, acknowledge, unknown
  always_comb begin
    res              = '0;
    res.frame_status = ST_UNKNOWN;
    if (sum != held[CSUM_POS]) begin
      res.frame_status = ST_CSUM;
    end else if (tail != TAIL_BYTE) begin
      res.frame_status = ST_TAIL;
    end else if (is_head && held[1] == CMD_MEAS) begin
      res.frame_status = ST_MEAS;
      res.pm25_value   = {held[3], held[2]};
      res.pm10_value   = {held[5], held[4]};
    end else if (is_head && held[1] == CMD_ACK) begin
      res.frame_status = ST_ACK;
    end
  end

endmodule

`default_nettype wire

>>> hdl/particle_sensor_reply_frame_parser.sv
// The result of a frame is registered on the beat that takes its tenth byte.
// Throughput: one byte per cycle; input stalls only while a result is waiting
// and out_tready is low.
// Reset (rst_n, synchronous, active low) clears the byte count, the running sum
// and the output valid; the held frame bytes are not reset.
`default_nettype none

module particle_sensor_reply_frame_parser import psrfp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] pm25_value, [31:16] pm10_value
  output logic [2:0]       out_tuser   // [2:0] frame_status
);

  logic [CNT_W-1:0] byte_count_r;
  logic [CNT_W-1:0] byte_count_nxt;
  logic [7:0]       running_sum_r;
  logic [7:0]       running_sum_nxt;
  held_bytes_t      held_r;
  logic             out_valid_r;
  frame_res_t       out_res_r;
  frame_res_t       dec_res;
  logic             in_beat;
  logic             is_tail;
  logic             in_sum_span;

  assign in_beat     = in_tvalid && in_tready;
  assign is_tail     = (byte_count_r >= CNT_W'(FRAME_LEN - 1));
  assign in_sum_span = (byte_count_r >= CNT_W'(SUM_FIRST)) &&
                       (byte_count_r <= CNT_W'(SUM_LAST));

  // Take a beat unless a held result cannot leave this cycle
  assign in_tready = !out_valid_r || out_tready;

  // Frame position and checksum accumulation
  always_comb begin
    byte_count_nxt  = byte_count_r;
    running_sum_nxt = running_sum_r;
    if (in_beat) begin
      if (is_tail) begin
        byte_count_nxt  = '0;
        running_sum_nxt = '0;
      end else begin
        byte_count_nxt = byte_count_r + CNT_W'(1);
        if (in_sum_span) begin
          running_sum_nxt = running_sum_r + in_tdata;
        end
      end
    end
  end

  psrfp_decode u_decode (
    .held (held_r),
    .sum  (running_sum_r),
    .tail (in_tdata),
    .res  (dec_res)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      running_sum_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      running_sum_r <= running_sum_nxt;
      if (in_beat && is_tail) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame bytes and result payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < HELD_N; i++) begin
      if (in_beat && byte_count_r == CNT_W'(i)) begin
        held_r[i] <= in_tdata;
      end
    end
    if (in_beat && is_tail) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.pm10_value, out_res_r.pm25_value};
  assign out_tuser  = out_res_r.frame_status;

endmodule

`default_nettype wire

>>> hdl/psrfp_checker.sv
`default_nettype none

module psrfp_checker import psrfp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A new result only follows an input beat
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without a closing byte");

  // Status is a defined code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_MEAS || out_tuser == ST_ACK ||
                    out_tuser == ST_UNKNOWN || out_tuser == ST_CSUM ||
                    out_tuser == ST_TAIL))
    else $error("undefined frame status");

  // Readings are zero unless the frame is a measurement
  a_zero_pm: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_MEAS |-> out_tdata == '0)
    else $error("readings on a non-measurement frame");

endmodule

bind particle_sensor_reply_frame_parser psrfp_checker u_psrfp_checker (.*);

`default_nettype wire
